FILE: sv/pfa_pkg.sv
package pfa_pkg;

  // Fixed sizes of the frame pool, owner table and allocation queue.
  localparam int NUM_FRAMES = 64;
  localparam int FRAME_AW   = 6;
  localparam int FRAME_CW   = 7;
  localparam int NUM_OWNERS = 16;
  localparam int OWNER_AW   = 4;
  localparam int FIFO_DEPTH = 64;
  localparam int QUEUE_AW   = 6;
  localparam int QUEUE_CW   = 7;
  localparam int USAGE_W    = 24;
  localparam logic [USAGE_W-1:0] USAGE_MAX = {USAGE_W{1'b1}};

  // Request modes.
  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_RELEASE = 2'd1;
  localparam logic [1:0] MODE_QUERY   = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_REL,
    ST_RDQ,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [3:0]  owner_id;
    logic [6:0]  pages_needed;
    logic [19:0] memory_required;
  } in_req_t;

  typedef struct packed {
    logic        ok;
    logic [6:0]  frames_changed;
    logic [6:0]  free_frames;
    logic        owner_present;
    logic [23:0] owner_bytes;
    logic [3:0]  oldest_owner;
    logic        queue_empty;
    logic [31:0] pages_in_total;
    logic [31:0] pages_out_total;
  } out_rsp_t;

  // Free stack port.
  typedef struct packed {
    logic                rd_en;
    logic [FRAME_AW-1:0] rd_addr;
    logic [FRAME_CW-1:0] low_mark;
    logic                wr_en;
    logic [FRAME_AW-1:0] wr_addr;
    logic [FRAME_AW-1:0] wr_data;
  } fs_ctl_t;

  // Owner table port.
  typedef struct packed {
    logic                clear_all;
    logic                rd_en;
    logic [FRAME_AW-1:0] rd_addr;
    logic                set_en;
    logic [FRAME_AW-1:0] set_addr;
    logic [OWNER_AW-1:0] set_owner;
    logic                clr_en;
    logic [FRAME_AW-1:0] clr_addr;
  } ot_ctl_t;

  // Allocation queue port.
  typedef struct packed {
    logic                wr_en;
    logic [QUEUE_AW-1:0] wr_addr;
    logic [OWNER_AW-1:0] wr_data;
    logic                rd_en;
    logic [QUEUE_AW-1:0] rd_addr;
  } fq_ctl_t;

endpackage

FILE: sv/pfa_free_stack.sv
module pfa_free_stack (
  input  logic                         clk,
  input  pfa_pkg::fs_ctl_t             ctl,
  output logic [pfa_pkg::FRAME_AW-1:0] rd_frame
);

  logic [pfa_pkg::FRAME_AW-1:0] mem [pfa_pkg::NUM_FRAMES];
  logic [pfa_pkg::FRAME_AW-1:0] rd_q;
  logic [pfa_pkg::FRAME_AW-1:0] addr_q;
  logic                         init_q;

  // Entries below the low mark were never pushed since the last reload and
  // are read back as their own index.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_q   <= mem[ctl.rd_addr];
      addr_q <= ctl.rd_addr;
      init_q <= ({1'b0, ctl.rd_addr} < ctl.low_mark);
    end
  end

  assign rd_frame = init_q ? addr_q : rd_q;

endmodule

FILE: sv/pfa_owner_table.sv
module pfa_owner_table (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pfa_pkg::ot_ctl_t             ctl,
  output logic                         rd_valid,
  output logic [pfa_pkg::OWNER_AW-1:0] rd_owner
);

  logic [pfa_pkg::OWNER_AW-1:0] mem [pfa_pkg::NUM_FRAMES];
  logic [pfa_pkg::NUM_FRAMES-1:0] valid_r;
  logic [pfa_pkg::NUM_FRAMES-1:0] valid_nxt;

  // Owner tags live in memory; one valid bit per frame in flops.
  always_ff @(posedge clk) begin
    if (ctl.set_en) begin
      mem[ctl.set_addr] <= ctl.set_owner;
    end
    if (ctl.rd_en) begin
      rd_owner <= mem[ctl.rd_addr];
      rd_valid <= valid_r[ctl.rd_addr];
    end
  end

  // Valid bit updates: reload clears all, allocate sets, release clears.
  always_comb begin
    valid_nxt = valid_r;
    if (ctl.set_en) begin
      valid_nxt[ctl.set_addr] = 1'b1;
    end
    if (ctl.clr_en) begin
      valid_nxt[ctl.clr_addr] = 1'b0;
    end
    if (ctl.clear_all) begin
      valid_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

endmodule

FILE: sv/pfa_queue.sv
module pfa_queue (
  input  logic                         clk,
  input  pfa_pkg::fq_ctl_t             ctl,
  output logic [pfa_pkg::OWNER_AW-1:0] rd_data
);

  logic [pfa_pkg::OWNER_AW-1:0] mem [pfa_pkg::FIFO_DEPTH];

  // Ring of owners in grant order.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[ctl.wr_addr] <= ctl.wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

endmodule

FILE: sv/page_frame_allocator_unit.sv
// Channel   Direction  Handshake              Payload
// in_       input      in_valid / in_ready    pfa_pkg::in_req_t
// out_      output     out_valid / out_ready  pfa_pkg::out_rsp_t
// cfg_      input      cfg_valid / cfg_ready  active_frames, 7 bits
//
// One request at a time. Query, refused allocate and mode 3 go straight to
// the queue read and the final step; an allocate does one free stack read a
// frame; a release does one owner table read for each of 64 frames.
// Reset is synchronous; no clearing pass is needed after it.
// A held result in the output register stalls only the final step.
module page_frame_allocator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pfa_pkg::in_req_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pfa_pkg::out_rsp_t  out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);

  localparam logic [pfa_pkg::FRAME_CW-1:0] NF_C = pfa_pkg::FRAME_CW'(pfa_pkg::NUM_FRAMES);
  localparam logic [pfa_pkg::QUEUE_CW-1:0] FD_C = pfa_pkg::QUEUE_CW'(pfa_pkg::FIFO_DEPTH);

  pfa_pkg::state_t state_r, state_nxt;
  pfa_pkg::in_req_t req_r;
  pfa_pkg::out_rsp_t out_r, rsp;
  logic out_valid_r;

  logic [pfa_pkg::FRAME_CW-1:0] fc_r, lw_r, k_r, chg_r;
  logic [pfa_pkg::QUEUE_AW-1:0] head_r;
  logic [pfa_pkg::QUEUE_CW-1:0] cnt_r;
  logic [31:0] pin_r, pout_r;
  logic [pfa_pkg::USAGE_W-1:0] usage_r [pfa_pkg::NUM_OWNERS];
  logic [pfa_pkg::FRAME_CW-1:0] ocnt_r [pfa_pkg::NUM_OWNERS];
  logic ok_r, p_valid_r;
  logic [pfa_pkg::FRAME_AW-1:0] p_frame_r;

  pfa_pkg::fs_ctl_t fs_ctl;
  pfa_pkg::ot_ctl_t ot_ctl;
  pfa_pkg::fq_ctl_t fq_ctl;
  logic [pfa_pkg::FRAME_AW-1:0] fs_frame;
  logic ot_valid;
  logic [pfa_pkg::OWNER_AW-1:0] ot_owner, fq_data;

  logic in_fire, cfg_fire, out_load, grant, issue, hit, push, alloc_done, rel_done;
  logic [pfa_pkg::FRAME_CW-1:0] fc_after, cfg_clamp;
  logic [pfa_pkg::USAGE_W:0] usage_sum;
  logic [pfa_pkg::USAGE_W-1:0] usage_cur, bytes_ext;

  pfa_free_stack u_fs (.clk(clk), .ctl(fs_ctl), .rd_frame(fs_frame));
  pfa_owner_table u_ot (.clk(clk), .rst_n(rst_n), .ctl(ot_ctl),
                        .rd_valid(ot_valid), .rd_owner(ot_owner));
  pfa_queue u_fq (.clk(clk), .ctl(fq_ctl), .rd_data(fq_data));

  // Handshakes and request decode.
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid;
  assign grant     = (in_data.mode == pfa_pkg::MODE_ALLOC) &&
                     (in_data.pages_needed <= fc_r) && (cnt_r != FD_C);
  assign out_load  = (state_r == pfa_pkg::ST_FIN) && (!out_valid_r || out_ready);
  assign fc_after  = fc_r - req_r.pages_needed;
  assign hit       = (state_r == pfa_pkg::ST_REL) && p_valid_r && ot_valid &&
                     (ot_owner == req_r.owner_id);
  assign push      = hit && (fc_r < NF_C);
  assign alloc_done = (state_r == pfa_pkg::ST_ALLOC) &&
                      (k_r == req_r.pages_needed) && !p_valid_r;
  assign rel_done  = (state_r == pfa_pkg::ST_REL) && (k_r == NF_C) && !p_valid_r;
  assign usage_cur = usage_r[in_data.owner_id];
  assign bytes_ext = pfa_pkg::USAGE_W'(in_data.memory_required);
  assign usage_sum = {1'b0, usage_cur} + {1'b0, bytes_ext};

  always_comb begin
    cfg_clamp = cfg_data;
    if (cfg_data == '0) begin
      cfg_clamp = pfa_pkg::FRAME_CW'(1);
    end else if (cfg_data > NF_C) begin
      cfg_clamp = NF_C;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (grant) begin
            state_nxt = pfa_pkg::ST_ALLOC;
          end else if (in_data.mode == pfa_pkg::MODE_RELEASE) begin
            state_nxt = pfa_pkg::ST_REL;
          end else begin
            state_nxt = pfa_pkg::ST_RDQ;
          end
        end
      end
      pfa_pkg::ST_ALLOC: if (alloc_done) state_nxt = pfa_pkg::ST_RDQ;
      pfa_pkg::ST_REL:   if (rel_done) state_nxt = pfa_pkg::ST_RDQ;
      pfa_pkg::ST_RDQ:   state_nxt = pfa_pkg::ST_FIN;
      pfa_pkg::ST_FIN:   if (out_load) state_nxt = pfa_pkg::ST_IDLE;
      default:           state_nxt = pfa_pkg::ST_IDLE;
    endcase
  end

  // Memory port controls.
  always_comb begin
    in_ready = (state_r == pfa_pkg::ST_IDLE);
    issue    = 1'b0;
    if (state_r == pfa_pkg::ST_ALLOC) begin
      issue = (k_r != req_r.pages_needed);
    end else if (state_r == pfa_pkg::ST_REL) begin
      issue = (k_r != NF_C);
    end

    fs_ctl          = '0;
    fs_ctl.rd_en    = issue && (state_r == pfa_pkg::ST_ALLOC);
    fs_ctl.rd_addr  = pfa_pkg::FRAME_AW'(fc_r - pfa_pkg::FRAME_CW'(1) - k_r);
    fs_ctl.low_mark = lw_r;
    fs_ctl.wr_en    = push;
    fs_ctl.wr_addr  = fc_r[pfa_pkg::FRAME_AW-1:0];
    fs_ctl.wr_data  = p_frame_r;

    ot_ctl           = '0;
    ot_ctl.clear_all = cfg_fire;
    ot_ctl.rd_en     = issue && (state_r == pfa_pkg::ST_REL);
    ot_ctl.rd_addr   = k_r[pfa_pkg::FRAME_AW-1:0];
    ot_ctl.set_en    = p_valid_r && (state_r == pfa_pkg::ST_ALLOC);
    ot_ctl.set_addr  = fs_frame;
    ot_ctl.set_owner = req_r.owner_id;
    ot_ctl.clr_en    = hit;
    ot_ctl.clr_addr  = p_frame_r;

    fq_ctl         = '0;
    fq_ctl.wr_en   = in_fire && grant;
    fq_ctl.wr_addr = head_r + cnt_r[pfa_pkg::QUEUE_AW-1:0];
    fq_ctl.wr_data = in_data.owner_id;
    fq_ctl.rd_en   = (state_r == pfa_pkg::ST_RDQ);
    fq_ctl.rd_addr = head_r;
  end

  // Result assembly.
  always_comb begin
    rsp                 = '0;
    rsp.ok              = ok_r;
    rsp.frames_changed  = chg_r;
    rsp.free_frames     = fc_r;
    rsp.owner_present   = (ocnt_r[req_r.owner_id] != '0);
    rsp.owner_bytes     = usage_r[req_r.owner_id];
    rsp.oldest_owner    = (cnt_r != '0) ? fq_data : '0;
    rsp.queue_empty     = (cnt_r == '0);
    rsp.pages_in_total  = pin_r;
    rsp.pages_out_total = pout_r;
  end

  // Control and bookkeeping registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pfa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      fc_r        <= NF_C;
      lw_r        <= NF_C;
      head_r      <= '0;
      cnt_r       <= '0;
      pin_r       <= '0;
      pout_r      <= '0;
      k_r         <= '0;
      p_valid_r   <= 1'b0;
      for (int i = 0; i < pfa_pkg::NUM_OWNERS; i++) begin
        usage_r[i] <= '0;
        ocnt_r[i]  <= '0;
      end
    end else begin
      state_r   <= state_nxt;
      p_valid_r <= issue;
      if (issue) begin
        k_r       <= k_r + pfa_pkg::FRAME_CW'(1);
        p_frame_r <= k_r[pfa_pkg::FRAME_AW-1:0];
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      // Reload of the frame pool.
      if (cfg_fire) begin
        fc_r <= cfg_clamp;
        lw_r <= cfg_clamp;
        for (int i = 0; i < pfa_pkg::NUM_OWNERS; i++) begin
          ocnt_r[i] <= '0;
        end
      end

      // Request entry: usage, queue and counters for this request.
      if (in_fire) begin
        req_r <= in_data;
        k_r   <= '0;
        chg_r <= '0;
        ok_r  <= (in_data.mode != pfa_pkg::MODE_UNUSED) &&
                 ((in_data.mode != pfa_pkg::MODE_ALLOC) || grant);
        if (grant) begin
          usage_r[in_data.owner_id] <= usage_sum[pfa_pkg::USAGE_W] ?
                                       pfa_pkg::USAGE_MAX : usage_sum[pfa_pkg::USAGE_W-1:0];
          ocnt_r[in_data.owner_id]  <= ocnt_r[in_data.owner_id] + in_data.pages_needed;
          cnt_r <= cnt_r + pfa_pkg::QUEUE_CW'(1);
          pin_r <= pin_r + 32'(in_data.pages_needed);
          chg_r <= in_data.pages_needed;
        end else if (in_data.mode == pfa_pkg::MODE_RELEASE) begin
          usage_r[in_data.owner_id] <= (usage_cur > bytes_ext) ?
                                       usage_cur - bytes_ext : '0;
          if (cnt_r != '0) begin
            head_r <= head_r + pfa_pkg::QUEUE_AW'(1);
            cnt_r  <= cnt_r - pfa_pkg::QUEUE_CW'(1);
          end
        end
      end

      // Allocate finishes: frames leave the stack.
      if (alloc_done) begin
        fc_r <= fc_after;
        if (fc_after < lw_r) begin
          lw_r <= fc_after;
        end
      end

      // Release: each owned frame goes back on the stack.
      if (hit) begin
        chg_r <= chg_r + pfa_pkg::FRAME_CW'(1);
      end
      if (push) begin
        fc_r <= fc_r + pfa_pkg::FRAME_CW'(1);
      end
      if (rel_done) begin
        ocnt_r[req_r.owner_id] <= '0;
        pout_r <= pout_r + 32'(chg_r);
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: tb/sv/page_frame_allocator_unit_chk.sv
`timescale 1ns / 1ps

// Watches all three channels of the allocator, keeps its own copy of the frame
// pool, owner tags, usage table and allocation queue, and compares every result.
module page_frame_allocator_unit_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  pfa_pkg::in_req_t   in_data,
  input  logic               out_valid,
  input  logic               out_ready,
  input  pfa_pkg::out_rsp_t  out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [6:0]         cfg_data,
  output int                 fail_count,
  output int                 pending_count,
  output int                 result_count
);

  // Shadow state of the allocator.
  logic [6:0]  frames_active;
  logic [5:0]  free_pool [pfa_pkg::NUM_FRAMES];
  logic [6:0]  free_depth;
  logic        tag_valid [pfa_pkg::NUM_FRAMES];
  logic [3:0]  tag_owner [pfa_pkg::NUM_FRAMES];
  logic [23:0] usage_of [pfa_pkg::NUM_OWNERS];
  logic [3:0]  owner_queue [pfa_pkg::FIFO_DEPTH];
  logic [5:0]  queue_head;
  logic [6:0]  queue_fill;
  logic [31:0] paged_in;
  logic [31:0] paged_out;
  pfa_pkg::out_rsp_t expected_rsp [$];

  // Fill the free pool with frames 0..n-1 so that frame n-1 is on top.
  function automatic void refill_pool(logic [6:0] n);
    for (int f = 0; f < pfa_pkg::NUM_FRAMES; f++) begin
      free_pool[f] = (f < n) ? 6'(f) : 6'd0;
      tag_valid[f] = 1'b0;
      tag_owner[f] = '0;
    end
    free_depth = n;
  endfunction

  function automatic pfa_pkg::out_rsp_t allocate_step(pfa_pkg::in_req_t req);
    pfa_pkg::out_rsp_t r;
    logic [24:0] sum;
    logic [5:0]  fr;
    logic        held;
    r = '0;
    if (req.mode == pfa_pkg::MODE_ALLOC) begin
      if (req.pages_needed <= free_depth && queue_fill < pfa_pkg::FIFO_DEPTH) begin
        for (int i = 0; i < req.pages_needed; i++) begin
          free_depth = free_depth - 7'd1;
          fr = free_pool[free_depth];
          tag_valid[fr] = 1'b1;
          tag_owner[fr] = req.owner_id;
        end
        sum = usage_of[req.owner_id] + req.memory_required;
        usage_of[req.owner_id] = sum > pfa_pkg::USAGE_MAX ? pfa_pkg::USAGE_MAX : sum[23:0];
        owner_queue[6'(queue_head + queue_fill)] = req.owner_id;
        queue_fill = queue_fill + 7'd1;
        paged_in = paged_in + 32'(req.pages_needed);
        r.frames_changed = req.pages_needed;
        r.ok = 1'b1;
      end
    end else if (req.mode == pfa_pkg::MODE_RELEASE) begin
      for (int f = 0; f < pfa_pkg::NUM_FRAMES; f++) begin
        if (tag_valid[f] && tag_owner[f] == req.owner_id) begin
          tag_valid[f] = 1'b0;
          tag_owner[f] = '0;
          if (free_depth < pfa_pkg::NUM_FRAMES) begin
            free_pool[free_depth] = 6'(f);
            free_depth = free_depth + 7'd1;
          end
          r.frames_changed = r.frames_changed + 7'd1;
        end
      end
      usage_of[req.owner_id] = usage_of[req.owner_id] > req.memory_required ?
                               usage_of[req.owner_id] - req.memory_required : '0;
      if (queue_fill > 0) begin
        queue_head = queue_head + 6'd1;
        queue_fill = queue_fill - 7'd1;
      end
      paged_out = paged_out + 32'(r.frames_changed);
      r.ok = 1'b1;
    end else if (req.mode == pfa_pkg::MODE_QUERY) begin
      r.ok = 1'b1;
    end
    held = 1'b0;
    for (int f = 0; f < pfa_pkg::NUM_FRAMES; f++)
      if (tag_valid[f] && tag_owner[f] == req.owner_id) held = 1'b1;
    r.free_frames     = free_depth;
    r.owner_present   = held;
    r.owner_bytes     = usage_of[req.owner_id];
    r.oldest_owner    = queue_fill > 0 ? owner_queue[queue_head] : '0;
    r.queue_empty     = queue_fill == 0;
    r.pages_in_total  = paged_in;
    r.pages_out_total = paged_out;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
    fail_count++;
  endtask

  always @(posedge clk) begin
    pfa_pkg::out_rsp_t want;
    logic [6:0] v;
    if (!rst_n) begin
      frames_active = 7'(pfa_pkg::NUM_FRAMES);
      refill_pool(frames_active);
      for (int o = 0; o < pfa_pkg::NUM_OWNERS; o++) usage_of[o] = '0;
      for (int q = 0; q < pfa_pkg::FIFO_DEPTH; q++) owner_queue[q] = '0;
      queue_head = '0;
      queue_fill = '0;
      paged_in = '0;
      paged_out = '0;
      expected_rsp.delete();
      fail_count = 0;
      result_count = 0;
    end else begin
      // A register write clamps the value and reloads the free pool.
      if (cfg_valid && cfg_ready) begin
        v = cfg_data;
        if (v < 1) v = 7'd1;
        if (v > pfa_pkg::NUM_FRAMES) v = 7'(pfa_pkg::NUM_FRAMES);
        frames_active = v;
        refill_pool(frames_active);
      end
      if (in_valid && in_ready) expected_rsp = {expected_rsp, allocate_step(in_data)};
      // Compare each result with the oldest expected one.
      if (out_valid && out_ready) begin
        result_count++;
        if (expected_rsp.size() == 0) begin
          report_mismatch("result with no request outstanding", 32'd1, 32'd0);
        end else begin
          want = expected_rsp.pop_front();
          if (out_data.ok != want.ok) report_mismatch("ok", out_data.ok, want.ok);
          if (out_data.frames_changed != want.frames_changed)
            report_mismatch("frames_changed", out_data.frames_changed, want.frames_changed);
          if (out_data.free_frames != want.free_frames)
            report_mismatch("free_frames", out_data.free_frames, want.free_frames);
          if (out_data.owner_present != want.owner_present)
            report_mismatch("owner_present", out_data.owner_present, want.owner_present);
          if (out_data.owner_bytes != want.owner_bytes)
            report_mismatch("owner_bytes", out_data.owner_bytes, want.owner_bytes);
          if (out_data.oldest_owner != want.oldest_owner)
            report_mismatch("oldest_owner", out_data.oldest_owner, want.oldest_owner);
          if (out_data.queue_empty != want.queue_empty)
            report_mismatch("queue_empty", out_data.queue_empty, want.queue_empty);
          if (out_data.pages_in_total != want.pages_in_total)
            report_mismatch("pages_in_total", out_data.pages_in_total, want.pages_in_total);
          if (out_data.pages_out_total != want.pages_out_total)
            report_mismatch("pages_out_total", out_data.pages_out_total,
                            want.pages_out_total);
        end
      end
    end
    pending_count = expected_rsp.size();
  end

endmodule

FILE: tb/sv/page_frame_allocator_unit_tb.sv
`timescale 1ns / 1ps

module page_frame_allocator_unit_tb;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  pfa_pkg::in_req_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  pfa_pkg::out_rsp_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [6:0] cfg_data = '0;
  int        fail_count;
  int        pending_count;
  int        result_count;
  int        cycle_count = 0;
  bit        calm_phase = 1'b0;
  int        request_count = 0;
  int        cfg_count = 0;

  localparam int CYCLE_LIMIT = 1500000;

  always #4 clk = ~clk;

  page_frame_allocator_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  page_frame_allocator_unit_chk chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_count(pending_count),
    .result_count(result_count)
  );

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("[page_frame_allocator_unit] ERROR");
      $finish;
    end
  end

  // Result side stalls in random bursts until the calm phase.
  initial begin
    int gap;
    @(posedge clk);
    forever begin
      if (!calm_phase && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 9);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Send one request and hold it until it is accepted. Valid stays high into
  // the next request unless an idle burst drops it first.
  task automatic send_request(logic [1:0] m, logic [3:0] who, logic [6:0] pages,
                              logic [19:0] bytes);
    int gap;
    if (!calm_phase && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: m, owner_id: who, pages_needed: pages, memory_required: bytes};
    do @(posedge clk); while (!in_ready);
    request_count++;
  endtask

  // Write the register once the block has drained.
  task automatic write_frames(logic [6:0] value);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_count++;
  endtask

  task automatic random_phase(int count);
    int r;
    logic [1:0] m;
    logic [6:0] pages;
    logic [19:0] bytes;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      m = r < 50 ? pfa_pkg::MODE_ALLOC :
          (r < 80 ? pfa_pkg::MODE_RELEASE :
          (r < 96 ? pfa_pkg::MODE_QUERY : pfa_pkg::MODE_UNUSED));
      r = $urandom_range(0, 9);
      pages = r < 7 ? 7'($urandom_range(0, 8)) :
              (r < 9 ? 7'($urandom_range(0, 64)) : 7'($urandom_range(0, 127)));
      bytes = $urandom_range(0, 3) == 0 ? 20'($urandom) : 20'($urandom_range(0, 4095));
      send_request(m, 4'($urandom), pages, bytes);
    end
  endtask

  initial begin
    int drain;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, refusals, saturation and unused mode.
    send_request(pfa_pkg::MODE_QUERY, 4'd0, 7'd0, 20'd0);
    send_request(pfa_pkg::MODE_RELEASE, 4'd3, 7'd0, 20'd5);
    send_request(pfa_pkg::MODE_ALLOC, 4'd15, 7'd0, 20'hFFFFF);
    send_request(pfa_pkg::MODE_ALLOC, 4'd1, 7'd64, 20'hFFFFF);
    send_request(pfa_pkg::MODE_ALLOC, 4'd2, 7'd1, 20'd1);
    send_request(pfa_pkg::MODE_ALLOC, 4'd1, 7'd127, 20'd0);
    for (int k = 0; k < 17; k++) send_request(pfa_pkg::MODE_ALLOC, 4'd1, 7'd0, 20'hFFFFF);
    send_request(pfa_pkg::MODE_UNUSED, 4'd1, 7'd0, 20'd0);
    send_request(pfa_pkg::MODE_RELEASE, 4'd1, 7'd0, 20'hFFFFF);
    send_request(pfa_pkg::MODE_RELEASE, 4'd9, 7'd0, 20'h00001);

    // Fill the allocation queue to overflow it.
    for (int k = 0; k < 66; k++) send_request(pfa_pkg::MODE_ALLOC, 4'd5, 7'd0, 20'd1);
    for (int k = 0; k < 66; k++) send_request(pfa_pkg::MODE_RELEASE, 4'd5, 7'd0, 20'd1);

    // Random phases across register settings, extremes and clamps included.
    write_frames(7'd0);
    random_phase(150);
    write_frames(7'd127);
    random_phase(250);
    write_frames(7'd1);
    random_phase(150);
    write_frames(7'd64);
    random_phase(250);
    write_frames(7'($urandom_range(2, 63)));
    random_phase(200);
    write_frames(7'd65);
    calm_phase = 1'b1;
    random_phase(150);
    in_valid <= 1'b0;

    drain = 0;
    while (pending_count != 0 && drain < 5000) begin
      @(posedge clk);
      drain++;
    end
    repeat (100) @(posedge clk);
    $display("Sent %0d requests, checked %0d results, %0d register writes.",
             request_count, result_count, cfg_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("[page_frame_allocator_unit] OK");
    end else begin
      $display("[page_frame_allocator_unit] ERROR");
    end
    $finish;
  end

endmodule
